[rtl/pan_tilt_servo_stepper_unit_defines.svh]
// Assertion macros shared by the checker of the pan/tilt servo stepper.
// Each macro expands to one labeled concurrent assertion clocked on clk
// and disabled while arst_n is low.
`ifndef PAN_TILT_SERVO_STEPPER_UNIT_DEFINES_SVH
`define PAN_TILT_SERVO_STEPPER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pts assertion failed");

// Next-cycle implication.
`define PTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pts assertion failed");

`endif

[rtl/pts_pkg.sv]
`timescale 1ns / 1ps

package pts_pkg;

	// Widths of positions and registers.
	localparam int POSITION_WIDTH = 16;
	localparam int STEP_W         = 8;
	localparam int DELAY_W        = 16;
	localparam int SUM_W          = POSITION_WIDTH + 2;
	localparam int FRAME_LEN      = 5;
	localparam int IDX_W          = 3;

	// Received characters that form a frame.
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_ONE  = 8'h31;

	// Home positions after reset.
	localparam logic [POSITION_WIDTH-1:0] HOME_X = POSITION_WIDTH'(3500);
	localparam logic [POSITION_WIDTH-1:0] HOME_Y = '0;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		CFG_MAX_POSITION = 2'd0,
		CFG_MIN_POSITION = 2'd1,
		CFG_STEP_DELAY   = 2'd2,
		CFG_STEP_SIZE    = 2'd3
	} cfg_index_t;

	// Command bit positions within a frame.
	localparam int BIT_UP    = 1;
	localparam int BIT_DOWN  = 2;
	localparam int BIT_LEFT  = 3;
	localparam int BIT_RIGHT = 4;

	// Per-axis control for one accepted tick.
	typedef struct packed {
		logic step;   // tick with a direction active on this axis
		logic neg;    // step toward lower positions
		logic prime;  // tick with no direction active at all
	} axis_ctrl_t;

	// One result word.
	typedef struct packed {
		logic [POSITION_WIDTH-1:0] compare_x;
		logic [POSITION_WIDTH-1:0] compare_y;
		logic                      frame_done;
		logic                      byte_rejected;
	} result_t;

endpackage

[rtl/pts_frame.sv]
`timescale 1ns / 1ps

module pts_frame import pts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_en,
	input  logic [7:0]           rx_byte,
	output logic [FRAME_LEN-1:0] command_bits,
	output logic                 frame_done,
	output logic                 byte_rejected
);

	logic [IDX_W-1:0]     frame_index_q;
	logic [FRAME_LEN-1:0] staged_q;
	logic [FRAME_LEN-1:0] command_q;
	logic                 is_digit;
	logic [FRAME_LEN-1:0] bit_mask;
	logic [FRAME_LEN-1:0] staged_nxt;
	logic [IDX_W-1:0]     index_inc;

	// Classify the byte and insert it into the staged frame.
	always_comb begin
		is_digit   = (rx_byte == CHAR_ZERO) || (rx_byte == CHAR_ONE);
		bit_mask   = FRAME_LEN'(1) << frame_index_q;
		staged_nxt = (rx_byte == CHAR_ONE) ? (staged_q | bit_mask) : (staged_q & ~bit_mask);
		index_inc  = frame_index_q + IDX_W'(1);
	end

	assign frame_done    = byte_en && is_digit && (index_inc >= IDX_W'(FRAME_LEN));
	assign byte_rejected = byte_en && !is_digit;
	assign command_bits  = command_q;

	// Frame assembly state; a complete frame replaces the command bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_index_q <= '0;
			staged_q      <= '0;
			command_q     <= '0;
		end else if (byte_en) begin
			if (!is_digit) begin
				frame_index_q <= '0;
				staged_q      <= '0;
			end else if (index_inc >= IDX_W'(FRAME_LEN)) begin
				command_q     <= staged_nxt;
				frame_index_q <= '0;
				staged_q      <= '0;
			end else begin
				frame_index_q <= index_inc;
				staged_q      <= staged_nxt;
			end
		end
	end

endmodule

[rtl/pts_axis.sv]
`timescale 1ns / 1ps

module pts_axis import pts_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [POSITION_WIDTH-1:0] rst_pos,
	input  axis_ctrl_t                ctrl,
	input  logic [POSITION_WIDTH-1:0] max_position,
	input  logic [POSITION_WIDTH-1:0] min_position,
	input  logic [DELAY_W-1:0]        step_delay,
	input  logic [STEP_W-1:0]         step_size,
	output logic [POSITION_WIDTH-1:0] compare_nxt
);

	logic        [DELAY_W-1:0]        delay_q;
	logic signed [POSITION_WIDTH:0]   pos_q;
	logic        [POSITION_WIDTH-1:0] compare_q;

	logic                             move;
	logic signed [SUM_W-1:0]          pos_ext;
	logic signed [SUM_W-1:0]          size_ext;
	logic signed [SUM_W-1:0]          max_ext;
	logic signed [SUM_W-1:0]          min_ext;
	logic signed [SUM_W-1:0]          sum;
	logic signed [SUM_W-1:0]          clamped;
	logic        [DELAY_W-1:0]        primed;

	// Step, then clamp to the window; the max test wins when min exceeds max.
	always_comb begin
		move     = ctrl.step && (delay_q >= step_delay);
		pos_ext  = SUM_W'(pos_q);
		size_ext = $signed({{(SUM_W-STEP_W){1'b0}}, step_size});
		max_ext  = $signed({2'b00, max_position});
		min_ext  = $signed({2'b00, min_position});
		sum      = ctrl.neg ? (pos_ext - size_ext) : (pos_ext + size_ext);
		if (sum > max_ext) begin
			clamped = max_ext;
		end else if (sum < min_ext) begin
			clamped = min_ext;
		end else begin
			clamped = sum;
		end
		primed = (step_delay == '1) ? step_delay : (step_delay + DELAY_W'(1));
	end

	// Compare value that this item leaves behind.
	always_comb begin
		if (ctrl.prime) begin
			compare_nxt = '0;
		end else if (move) begin
			compare_nxt = clamped[POSITION_WIDTH-1:0];
		end else begin
			compare_nxt = compare_q;
		end
	end

	// Axis state: delay counter, position and compare value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q   <= '0;
			pos_q     <= $signed({1'b0, rst_pos});
			compare_q <= rst_pos;
		end else begin
			compare_q <= compare_nxt;
			if (ctrl.prime) begin
				delay_q <= primed;
			end else if (ctrl.step) begin
				if (move) begin
					delay_q <= '0;
					pos_q   <= clamped[POSITION_WIDTH:0];
				end else begin
					delay_q <= delay_q + DELAY_W'(1);
				end
			end
		end
	end

endmodule

[rtl/pts_outbuf.sv]
`timescale 1ns / 1ps

module pts_outbuf import pts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_word,
	output logic    can_push,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_word
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;

	assign can_push  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	// Output register backed by one skid word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload words.
	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			out_q <= skid_valid_q ? skid_q : push_word;
		end else if (push) begin
			skid_q <= push_word;
		end
	end

endmodule

[rtl/pan_tilt_servo_stepper_unit.sv]
`timescale 1ns / 1ps
// A result word is registered in the output register, or in the skid word while the output stalls.
// Throughput: one item per cycle while in_ready is high; all state updates in one pass of clamp and compare logic.
// A one-word skid behind the output register keeps input accepting while a result waits.
// Reset (arst_n low, asynchronous) clears the frame and delays, homes pan to 3500,
// tilt to 0, and loads the configuration registers with their default values.

module pan_tilt_servo_stepper_unit import pts_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [1:0]                cfg_index,
	input  logic [15:0]               cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      operation,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [POSITION_WIDTH-1:0] compare_x,
	output logic [POSITION_WIDTH-1:0] compare_y,
	output logic                      frame_done,
	output logic                      byte_rejected
);

	logic [POSITION_WIDTH-1:0] max_position_q;
	logic [POSITION_WIDTH-1:0] min_position_q;
	logic [DELAY_W-1:0]        step_delay_q;
	logic [STEP_W-1:0]         step_size_q;

	logic                      accept;
	logic                      tick_en;
	logic                      any_dir;
	logic [FRAME_LEN-1:0]      command_bits;
	logic                      done_w;
	logic                      rejected_w;
	axis_ctrl_t                ctrl_x;
	axis_ctrl_t                ctrl_y;
	logic [POSITION_WIDTH-1:0] cmp_x_nxt;
	logic [POSITION_WIDTH-1:0] cmp_y_nxt;
	result_t                   res_word;
	result_t                   out_word;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_position_q <= POSITION_WIDTH'(5000);
			min_position_q <= POSITION_WIDTH'(950);
			step_delay_q   <= DELAY_W'(100);
			step_size_q    <= STEP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_MAX_POSITION: max_position_q <= cfg_data[POSITION_WIDTH-1:0];
				CFG_MIN_POSITION: min_position_q <= cfg_data[POSITION_WIDTH-1:0];
				CFG_STEP_DELAY:   step_delay_q   <= cfg_data[DELAY_W-1:0];
				CFG_STEP_SIZE:    step_size_q    <= cfg_data[STEP_W-1:0];
				default:          step_size_q    <= step_size_q;
			endcase
		end
	end

	assign accept  = in_valid && in_ready;
	assign tick_en = accept && operation;

	// Frame assembly from received bytes.
	pts_frame u_frame (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_en      (accept && !operation),
		.rx_byte      (rx_byte),
		.command_bits (command_bits),
		.frame_done   (done_w),
		.byte_rejected(rejected_w)
	);

	// Direction decode; up beats down and left beats right.
	always_comb begin
		any_dir      = command_bits[BIT_UP] || command_bits[BIT_DOWN] ||
		               command_bits[BIT_LEFT] || command_bits[BIT_RIGHT];
		ctrl_y.prime = tick_en && !any_dir;
		ctrl_y.step  = tick_en && (command_bits[BIT_UP] || command_bits[BIT_DOWN]);
		ctrl_y.neg   = !command_bits[BIT_UP];
		ctrl_x.prime = tick_en && !any_dir;
		ctrl_x.step  = tick_en && (command_bits[BIT_LEFT] || command_bits[BIT_RIGHT]);
		ctrl_x.neg   = !command_bits[BIT_LEFT];
	end

	// Pan axis.
	pts_axis u_axis_x (
		.clk         (clk),
		.arst_n      (arst_n),
		.rst_pos     (HOME_X),
		.ctrl        (ctrl_x),
		.max_position(max_position_q),
		.min_position(min_position_q),
		.step_delay  (step_delay_q),
		.step_size   (step_size_q),
		.compare_nxt (cmp_x_nxt)
	);

	// Tilt axis.
	pts_axis u_axis_y (
		.clk         (clk),
		.arst_n      (arst_n),
		.rst_pos     (HOME_Y),
		.ctrl        (ctrl_y),
		.max_position(max_position_q),
		.min_position(min_position_q),
		.step_delay  (step_delay_q),
		.step_size   (step_size_q),
		.compare_nxt (cmp_y_nxt)
	);

	// Result word for the accepted item.
	always_comb begin
		res_word.compare_x     = cmp_x_nxt;
		res_word.compare_y     = cmp_y_nxt;
		res_word.frame_done    = done_w;
		res_word.byte_rejected = rejected_w;
	end

	pts_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.push_word(res_word),
		.can_push (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_word (out_word)
	);

	assign compare_x     = out_word.compare_x;
	assign compare_y     = out_word.compare_y;
	assign frame_done    = out_word.frame_done;
	assign byte_rejected = out_word.byte_rejected;

endmodule

[rtl/pts_checker.sv]
`timescale 1ns / 1ps
`include "pan_tilt_servo_stepper_unit_defines.svh"

module pts_checker import pts_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [POSITION_WIDTH-1:0] compare_x,
	input logic [POSITION_WIDTH-1:0] compare_y,
	input logic                      frame_done,
	input logic                      byte_rejected
);

	// A stalled result word holds its payload.
	`PTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(compare_x) && $stable(compare_y) && $stable(frame_done) && $stable(byte_rejected))

	// A byte cannot both complete a frame and be rejected.
	`PTS_ASSERT_NOW(a_flags_excl, out_valid, !(frame_done && byte_rejected))

	// Back-pressure on input only happens with a result waiting.
	`PTS_ASSERT_NOW(a_full_has_out, !in_ready, out_valid)

	// A word taken in while the output is stalled fills the skid stage.
	`PTS_ASSERT_NEXT(a_skid_fill, in_valid && in_ready && out_valid && !out_ready, !in_ready)

endmodule

bind pan_tilt_servo_stepper_unit pts_checker u_pts_checker (.*);

[bench/stepper_check_pkg.sv]
`timescale 1ns / 1ps

package stepper_check_pkg;
	import pts_pkg::*;

	// Kinds of input word.
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Axis slots of the position tracker.
	localparam int AXIS_PAN  = 0;
	localparam int AXIS_TILT = 1;

	// Mismatch lines printed before the rest are only counted.
	localparam int PRINT_LIMIT = 100;

	// Tracks frame assembly and both servo positions, and holds the compare
	// words that the block owes for the input words accepted so far.
	class stepper_scoreboard;
		int          max_pos;
		int          min_pos;
		int          step_delay;
		int          step_size;
		logic [2:0]  frame_idx;
		logic [4:0]  staged_bits;
		logic [4:0]  command_bits;
		int          axis_delay[2];
		int          axis_pos[2];
		logic [POSITION_WIDTH-1:0] axis_cmp[2];
		result_t     expected_compares[$];
		int          errors;

		function new();
			max_pos = 5000;
			min_pos = 950;
			step_delay = 100;
			step_size = 1;
			frame_idx = '0;
			staged_bits = '0;
			command_bits = '0;
			axis_delay[AXIS_PAN] = 0;
			axis_delay[AXIS_TILT] = 0;
			axis_pos[AXIS_PAN] = HOME_X;
			axis_pos[AXIS_TILT] = HOME_Y;
			axis_cmp[AXIS_PAN] = HOME_X;
			axis_cmp[AXIS_TILT] = HOME_Y;
			errors = 0;
		endfunction

		// Mirror a configuration register write.
		function void set_reg(cfg_index_t idx, logic [15:0] value);
			case (idx)
				CFG_MAX_POSITION: max_pos = value;
				CFG_MIN_POSITION: min_pos = value;
				CFG_STEP_DELAY:   step_delay = value;
				CFG_STEP_SIZE:    step_size = value[7:0];
				default: ;
			endcase
		endfunction

		// One step attempt on an axis; the delay counter gates the move and
		// the clamp tests the maximum before the minimum.
		function void step_axis(int axis, int dir);
			int p;
			if (axis_delay[axis] < step_delay) begin
				axis_delay[axis]++;
				return;
			end
			axis_delay[axis] = 0;
			p = axis_pos[axis] + dir * step_size;
			if (p > max_pos)
				p = max_pos;
			else if (p < min_pos)
				p = min_pos;
			axis_pos[axis] = p;
			axis_cmp[axis] = p[POSITION_WIDTH-1:0];
		endfunction

		// Work out the compare word caused by one accepted input word.
		function void predict_compare(logic op, logic [7:0] ch);
			result_t r;
			int      primed;
			r.frame_done = 1'b0;
			r.byte_rejected = 1'b0;
			if (op == OP_BYTE) begin
				if (ch == CHAR_ZERO || ch == CHAR_ONE) begin
					staged_bits[frame_idx] = (ch == CHAR_ONE);
					frame_idx++;
					if (frame_idx >= FRAME_LEN) begin
						command_bits = staged_bits;
						frame_idx = '0;
						staged_bits = '0;
						r.frame_done = 1'b1;
					end
				end else begin
					frame_idx = '0;
					staged_bits = '0;
					r.byte_rejected = 1'b1;
				end
			end else if (command_bits[BIT_RIGHT:BIT_UP] == '0) begin
				// No direction: outputs go quiet and the next move is immediate.
				primed = (step_delay >= 16'hFFFF) ? 16'hFFFF : step_delay + 1;
				axis_delay[AXIS_PAN] = primed;
				axis_delay[AXIS_TILT] = primed;
				axis_cmp[AXIS_PAN] = '0;
				axis_cmp[AXIS_TILT] = '0;
			end else begin
				if (command_bits[BIT_UP])
					step_axis(AXIS_TILT, 1);
				else if (command_bits[BIT_DOWN])
					step_axis(AXIS_TILT, -1);
				if (command_bits[BIT_LEFT])
					step_axis(AXIS_PAN, 1);
				else if (command_bits[BIT_RIGHT])
					step_axis(AXIS_PAN, -1);
			end
			r.compare_x = axis_cmp[AXIS_PAN];
			r.compare_y = axis_cmp[AXIS_TILT];
			expected_compares.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= PRINT_LIMIT)
				$display("%0t ns: %s", $time, msg);
		endtask

		// Compare one accepted output word with the oldest expectation.
		task check_compare(result_t got);
			result_t want;
			if (expected_compares.size() == 0) begin
				report_mismatch("output word with nothing expected");
				return;
			end
			want = expected_compares.pop_front();
			if (got.compare_x !== want.compare_x)
				report_mismatch($sformatf("compare_x got %0d expected %0d",
					got.compare_x, want.compare_x));
			if (got.compare_y !== want.compare_y)
				report_mismatch($sformatf("compare_y got %0d expected %0d",
					got.compare_y, want.compare_y));
			if (got.frame_done !== want.frame_done)
				report_mismatch($sformatf("frame_done got %b expected %b",
					got.frame_done, want.frame_done));
			if (got.byte_rejected !== want.byte_rejected)
				report_mismatch($sformatf("byte_rejected got %b expected %b",
					got.byte_rejected, want.byte_rejected));
		endtask

		function int pending();
			return expected_compares.size();
		endfunction
	endclass

endpackage

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import pts_pkg::*;
	import stepper_check_pkg::*;

	// Cycles the output side holds off to back the block up.
	localparam int HOLD_CYCLES = 300;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_we;
	logic [1:0]                cfg_index;
	logic [15:0]               cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      operation;
	logic [7:0]                rx_byte;
	logic                      out_valid;
	logic                      out_ready;
	logic [POSITION_WIDTH-1:0] compare_x;
	logic [POSITION_WIDTH-1:0] compare_y;
	logic                      frame_done;
	logic                      byte_rejected;
	result_t                   seen;

	bit                calm;
	bit                hold_output;
	int                words_sent;
	stepper_scoreboard sb;

	pan_tilt_servo_stepper_unit dut (.*);

	assign seen = {compare_x, compare_y, frame_done, byte_rejected};

	always #5 clk = ~clk;

	// Mostly short gaps, now and then a long one; none during calm stretches.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Offer one input word and hold it until the block takes it.
	task automatic send_word(logic op, logic [7:0] ch);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		rx_byte <= ch;
		do @(posedge clk); while (!in_ready);
		sb.predict_compare(op, ch);
		words_sent++;
	endtask

	task automatic send_tick();
		send_word(OP_TICK, 8'($urandom));
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_tick();
	endtask

	// Five characters, first character is bit zero (the space bit).
	task automatic send_frame(logic [4:0] bits);
		for (int i = 0; i < FRAME_LEN; i++)
			send_word(OP_BYTE, bits[i] ? CHAR_ONE : CHAR_ZERO);
	endtask

	// Mostly whole frames followed by ticks, plus broken frames and noise.
	task automatic random_traffic(int n_words);
		int          stop;
		int          kind;
		logic [7:0]  junk;
		stop = words_sent + n_words;
		while (words_sent < stop) begin
			calm = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_frame(5'($urandom));
				send_ticks($urandom_range(1, 24));
			end else if (kind < 85) begin
				repeat ($urandom_range(0, 4))
					send_word(OP_BYTE, $urandom_range(0, 1) ? CHAR_ONE : CHAR_ZERO);
				do junk = 8'($urandom); while (junk == CHAR_ZERO || junk == CHAR_ONE);
				send_word(OP_BYTE, junk);
			end else begin
				repeat ($urandom_range(1, 6)) begin
					if ($urandom_range(0, 1))
						send_tick();
					else
						send_word(OP_BYTE, 8'($urandom));
				end
			end
		end
		calm = 1'b0;
	endtask

	// Let every owed word come out, then a short pause for the pipeline.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		sb.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic load_settings(int mx, int mn, int dly, int sz);
		wait_drained();
		write_reg(CFG_MAX_POSITION, mx[15:0]);
		write_reg(CFG_MIN_POSITION, mn[15:0]);
		write_reg(CFG_STEP_DELAY, dly[15:0]);
		write_reg(CFG_STEP_SIZE, sz[15:0]);
		cfg_we <= 1'b0;
	endtask

	// Output side: random stalls, and a long hold-off when asked.
	initial begin
		int n;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_output) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_output = 1'b0;
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	// Check each output word as it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_compare(seen);
	end

	// Main sequence.
	initial begin
		int mx;
		int mn;
		sb = new();
		calm = 1'b0;
		hold_output = 1'b0;
		words_sent = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_MAX_POSITION;
		cfg_data <= '0;
		in_valid <= 1'b0;
		operation <= OP_BYTE;
		rx_byte <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset settings.
		send_word(OP_TICK, 8'hFF);      // no command: prime and zero outputs
		send_frame(5'b00010);           // up only
		send_tick();                    // primed delay: immediate move, clamps to min
		send_tick();                    // delay counting
		send_frame(5'b11111);           // all bits: up and left win
		send_tick();
		send_word(OP_BYTE, CHAR_ONE);
		send_word(OP_BYTE, CHAR_ONE);
		send_word(OP_BYTE, 8'h00);      // drops the partial frame
		send_word(OP_BYTE, 8'hFF);
		send_frame(5'b10100);           // down and right
		send_tick();

		// Extremes, with the output held off to fill the block.
		load_settings(65535, 0, 0, 255);
		hold_output = 1'b1;
		random_traffic(200);

		// Minimum above maximum, delay one below its largest value, zero step.
		load_settings(0, 65535, 65534, 0);
		random_traffic(150);

		load_settings(4000, 1000, 0, 1);
		random_traffic(200);

		load_settings(2500, 500, 3, 37);
		hold_output = 1'b1;
		random_traffic(200);

		// Minimum equal to maximum.
		load_settings(1200, 1200, 1, 200);
		random_traffic(150);

		repeat (4) begin
			mx = $urandom_range(0, 65535);
			if ($urandom_range(0, 4) == 0)
				mn = $urandom_range(0, 65535);
			else
				mn = $urandom_range(0, mx);
			load_settings(mx, mn, $urandom_range(0, 5), $urandom_range(0, 255));
			random_traffic(200);
		end

		wait_drained();
		repeat (4) @(posedge clk);
		if (sb.errors == 0)
			$display("pan_tilt_servo_stepper_unit: match");
		else
			$display("pan_tilt_servo_stepper_unit: mismatch");
		$finish;
	end

	// Run limit.
	initial begin
		#8000000;
		$display("pan_tilt_servo_stepper_unit: mismatch");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_frame.sv
rtl/pts_axis.sv
rtl/pts_outbuf.sv
rtl/pan_tilt_servo_stepper_unit.sv
rtl/pts_checker.sv
bench/stepper_check_pkg.sv
bench/tb_top.sv
